[rtl/core/pfs_pkg.sv]
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared constants, request codes and types of the priority FIFO scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pfs_pkg;

  localparam int TASKS  = 64;
  localparam int LEVELS = 16;

  localparam int ID_W    = $clog2(TASKS);
  localparam int PTR_W   = $clog2(TASKS + 1);
  localparam int LEVEL_W = $clog2(LEVELS);

  localparam int REQ_W   = 2;
  localparam int TID_W   = 6;
  localparam int PRIO_W  = 4;
  localparam int COUNT_W = 7;

  localparam logic [PTR_W-1:0]   NONE_MARK = PTR_W'(TASKS);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_YIELD = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_TAIL,
    ST_ADD_LINK,
    ST_POP_READ,
    ST_POP_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               found;
    logic [LEVEL_W-1:0] level;
  } level_pick_t;

endpackage

`default_nettype wire

[rtl/core/pfs_ram.sv]
// ----------------------------------------------------------------------------
// pfs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/pfs_level_pick.sv]
// ----------------------------------------------------------------------------
// pfs_level_pick
// Finds the highest non-empty priority level in the occupancy bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_level_pick (
  input  wire logic [pfs_pkg::LEVELS-1:0] mask,
  output pfs_pkg::level_pick_t            pick
);

  always_comb begin
    pick.found = 1'b0;
    pick.level = '0;
    for (int i = 0; i < pfs_pkg::LEVELS; i++) begin
      if (mask[i]) begin
        pick.found = 1'b1;
        pick.level = pfs_pkg::LEVEL_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/priority_fifo_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// priority_fifo_scheduler_unit
// Multilevel ready-queue scheduler with one linked FIFO per priority level.
// ----------------------------------------------------------------------------
// The input channel carries one request per transaction: add a task at its
// priority, pop the head of the highest non-empty level, or yield (add, then
// pop). Each request produces exactly one result transaction on the output
// channel with the popped task, an empty flag and the queued task count.
// Requests are handled one at a time by a sequencer around the link table
// RAM, whose single write port and registered read set the steps: an add
// writes the new tail in ST_ADD_TAIL and, when the level already holds
// tasks, links the old tail in ST_ADD_LINK; a pop reads the head in
// ST_POP_READ and, if found, unlinks it in ST_POP_UPDATE; a yield runs
// both in turn, and all end in ST_FINISH, an unused request code directly.
// The result sits in an output register; the next request is accepted while
// it waits, and a stall on the output holds the result and keeps the block
// from finishing further requests. After reset all levels are empty, the
// count is zero and the block is ready to accept a request.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_fifo_scheduler_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [pfs_pkg::REQ_W-1:0]   req_type,
  input  wire logic [pfs_pkg::TID_W-1:0]   task_id,
  input  wire logic [pfs_pkg::PRIO_W-1:0]  task_priority,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             chosen_valid,
  output logic      [pfs_pkg::TID_W-1:0]   chosen_task,
  output logic                             empty_error,
  output logic      [pfs_pkg::COUNT_W-1:0] queued_count
);

  pfs_pkg::state_t state, state_next;

  logic [pfs_pkg::REQ_W-1:0]   req_r;
  logic [pfs_pkg::ID_W-1:0]    tid_r;
  logic [pfs_pkg::LEVEL_W-1:0] prio_r;
  logic [pfs_pkg::PTR_W-1:0]   last_r;
  logic [pfs_pkg::LEVEL_W-1:0] pr_r;
  logic [pfs_pkg::PTR_W-1:0]   first_r;
  logic                        res_valid;
  logic [pfs_pkg::ID_W-1:0]    res_task;
  logic                        res_err;

  logic [pfs_pkg::PTR_W-1:0]   level_head [pfs_pkg::LEVELS];
  logic [pfs_pkg::PTR_W-1:0]   level_tail [pfs_pkg::LEVELS];
  logic [pfs_pkg::LEVELS-1:0]  nonempty_mask;
  logic [pfs_pkg::COUNT_W-1:0] task_count;

  logic                        in_take;
  logic                        out_load;
  logic                        is_yield;
  logic                        tid_in_range;
  logic [pfs_pkg::LEVEL_W-1:0] prio_clamped;
  logic [pfs_pkg::PTR_W-1:0]   tail_last;
  logic                        tail_linked;
  logic [pfs_pkg::PTR_W-1:0]   head_first;
  logic                        head_ok;
  logic [pfs_pkg::PTR_W-1:0]   link_next;
  pfs_pkg::level_pick_t        pick;

  logic                        ram_we;
  logic [pfs_pkg::ID_W-1:0]    ram_waddr;
  logic [pfs_pkg::PTR_W-1:0]   ram_wdata;
  logic [pfs_pkg::ID_W-1:0]    ram_raddr;
  logic [pfs_pkg::PTR_W-1:0]   ram_rdata;

  pfs_ram #(
    .WIDTH (pfs_pkg::PTR_W),
    .DEPTH (pfs_pkg::TASKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfs_level_pick u_level_pick (
    .mask (nonempty_mask),
    .pick (pick)
  );

  assign in_take      = in_valid && (state == pfs_pkg::ST_IDLE);
  assign out_load     = (state == pfs_pkg::ST_FINISH) && (!out_valid || !out_stall);
  assign is_yield     = (req_r == pfs_pkg::REQ_YIELD);
  assign tid_in_range = int'(task_id) < pfs_pkg::TASKS;
  assign prio_clamped = (int'(task_priority) >= pfs_pkg::LEVELS) ?
                        pfs_pkg::LEVEL_W'(pfs_pkg::LEVELS - 1) :
                        pfs_pkg::LEVEL_W'(task_priority);
  assign tail_last    = level_tail[prio_r];
  assign tail_linked  = tail_last < pfs_pkg::NONE_MARK;
  assign head_first   = level_head[pick.level];
  assign head_ok      = head_first < pfs_pkg::NONE_MARK;
  assign link_next    = (ram_rdata > pfs_pkg::NONE_MARK) ? pfs_pkg::NONE_MARK : ram_rdata;

  always_comb begin
    state_next = state;
    case (state)
      pfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if ((req_type inside {pfs_pkg::REQ_ADD, pfs_pkg::REQ_YIELD}) && tid_in_range) begin
            state_next = pfs_pkg::ST_ADD_TAIL;
          end else if (req_type inside {pfs_pkg::REQ_POP, pfs_pkg::REQ_YIELD}) begin
            state_next = pfs_pkg::ST_POP_READ;
          end else begin
            state_next = pfs_pkg::ST_FINISH;
          end
        end
      end
      pfs_pkg::ST_ADD_TAIL: begin
        if (tail_linked) begin
          state_next = pfs_pkg::ST_ADD_LINK;
        end else if (is_yield) begin
          state_next = pfs_pkg::ST_POP_READ;
        end else begin
          state_next = pfs_pkg::ST_FINISH;
        end
      end
      pfs_pkg::ST_ADD_LINK: begin
        state_next = is_yield ? pfs_pkg::ST_POP_READ : pfs_pkg::ST_FINISH;
      end
      pfs_pkg::ST_POP_READ: begin
        state_next = (pick.found && head_ok) ? pfs_pkg::ST_POP_UPDATE : pfs_pkg::ST_FINISH;
      end
      pfs_pkg::ST_POP_UPDATE: begin
        state_next = pfs_pkg::ST_FINISH;
      end
      pfs_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = pfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = (state != pfs_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = tid_r;
    ram_wdata = pfs_pkg::NONE_MARK;
    ram_raddr = head_first[pfs_pkg::ID_W-1:0];
    case (state)
      pfs_pkg::ST_ADD_TAIL: begin
        ram_we = 1'b1;
      end
      pfs_pkg::ST_ADD_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = last_r[pfs_pkg::ID_W-1:0];
        ram_wdata = pfs_pkg::PTR_W'(tid_r);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty_mask <= '0;
      task_count    <= '0;
      for (int i = 0; i < pfs_pkg::LEVELS; i++) begin
        level_head[i] <= pfs_pkg::NONE_MARK;
        level_tail[i] <= pfs_pkg::NONE_MARK;
      end
    end else begin
      case (state)
        pfs_pkg::ST_ADD_TAIL: begin
          if (task_count != pfs_pkg::COUNT_MAX) begin
            task_count <= task_count + 1'b1;
          end
          if (!tail_linked) begin
            level_head[prio_r]    <= pfs_pkg::PTR_W'(tid_r);
            nonempty_mask[prio_r] <= 1'b1;
          end
          level_tail[prio_r] <= pfs_pkg::PTR_W'(tid_r);
        end
        pfs_pkg::ST_POP_READ: begin
          if (pick.found && !head_ok) begin
            level_head[pick.level]    <= pfs_pkg::NONE_MARK;
            level_tail[pick.level]    <= pfs_pkg::NONE_MARK;
            nonempty_mask[pick.level] <= 1'b0;
          end
        end
        pfs_pkg::ST_POP_UPDATE: begin
          if (task_count != '0) begin
            task_count <= task_count - 1'b1;
          end
          level_head[pr_r] <= link_next;
          if (link_next == pfs_pkg::NONE_MARK) begin
            level_tail[pr_r]    <= pfs_pkg::NONE_MARK;
            nonempty_mask[pr_r] <= 1'b0;
          end
        end
        default: begin
          task_count <= task_count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r     <= req_type;
      tid_r     <= pfs_pkg::ID_W'(task_id);
      prio_r    <= prio_clamped;
      res_valid <= 1'b0;
      res_task  <= '0;
      res_err   <= 1'b0;
    end
    if (state == pfs_pkg::ST_ADD_TAIL) begin
      last_r <= tail_last;
    end
    if (state == pfs_pkg::ST_POP_READ) begin
      pr_r    <= pick.level;
      first_r <= head_first;
      if (!(pick.found && head_ok)) begin
        res_err <= 1'b1;
      end
    end
    if (state == pfs_pkg::ST_POP_UPDATE) begin
      res_valid <= 1'b1;
      res_task  <= first_r[pfs_pkg::ID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      chosen_valid <= res_valid;
      chosen_task  <= pfs_pkg::TID_W'(res_task);
      empty_error  <= res_err;
      queued_count <= task_count;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pfs_checker.sv]
// ----------------------------------------------------------------------------
// pfs_checker
// Port-level checks of the priority FIFO scheduler result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        chosen_valid,
  input wire logic [pfs_pkg::TID_W-1:0]   chosen_task,
  input wire logic                        empty_error,
  input wire logic [pfs_pkg::COUNT_W-1:0] queued_count
);

  logic                        have_last;
  logic [pfs_pkg::COUNT_W-1:0] last_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
    end else if (out_valid && !out_stall) begin
      have_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      last_count <= queued_count;
    end
  end

  a_pop_xor_error: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(chosen_valid && empty_error))
    else $error("A result reports both a chosen task and an empty error.");

  a_idle_task_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !chosen_valid) |-> (chosen_task == '0))
    else $error("A result without a chosen task carries a nonzero task id.");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && have_last) |->
      ((queued_count == last_count) ||
       (queued_count == last_count + 1'b1) ||
       (queued_count == last_count - 1'b1)))
    else $error("The queued count moved by more than one between transactions.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(chosen_task) && $stable(queued_count)))
    else $error("A stalled result changed or was dropped.");

endmodule

bind priority_fifo_scheduler_unit pfs_checker u_pfs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .chosen_valid (chosen_valid),
  .chosen_task  (chosen_task),
  .empty_error  (empty_error),
  .queued_count (queued_count)
);

`default_nettype wire

[bench/priority_fifo_scheduler_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_fifo_scheduler_unit_tb
// Self-checking testbench for the multilevel priority FIFO scheduler.
// ----------------------------------------------------------------------------
// Requests are driven on the input channel. The bench keeps its own linked
// per-level ready queues, count and bitmap, and from them works out the
// result of every accepted transaction. Each result transaction is checked
// field by field against the oldest expected result. Directed tests cover an
// empty scheduler, the unused request code, priority and FIFO order, yield,
// a task queued twice and count saturation. Random traffic with idle cycles
// on both sides and a long output hold-off covers the rest.
// ----------------------------------------------------------------------------

module priority_fifo_scheduler_unit_tb;
  import pfs_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 520;
  localparam int QUIET_LIMIT = 1000;

  typedef struct {
    logic               chosen_valid;
    logic [TID_W-1:0]   chosen_task;
    logic               empty_error;
    logic [COUNT_W-1:0] queued_count;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [REQ_W-1:0] req_type;
  logic [TID_W-1:0] task_id;
  logic [PRIO_W-1:0] task_priority;
  logic out_valid;
  logic out_stall;
  logic chosen_valid;
  logic [TID_W-1:0] chosen_task;
  logic empty_error;
  logic [COUNT_W-1:0] queued_count;

  logic [PTR_W-1:0] nxt_task [TASKS];
  logic [PTR_W-1:0] lvl_head [LEVELS];
  logic [PTR_W-1:0] lvl_tail [LEVELS];
  logic [LEVELS-1:0] ready_mask;
  logic [COUNT_W-1:0] ready_count;
  logic [TASKS-1:0] busy_id;

  sched_result_t pending_results [$];
  int error_count = 0;
  int hold_left = 0;
  bit idle_enable = 1'b1;

  priority_fifo_scheduler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .task_id      (task_id),
    .task_priority(task_priority),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen_valid (chosen_valid),
    .chosen_task  (chosen_task),
    .empty_error  (empty_error),
    .queued_count (queued_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic void queue_task(input logic [TID_W-1:0] tid, input int lvl);
    logic [PTR_W-1:0] last;
    last = lvl_tail[lvl];
    if (ready_count != COUNT_MAX) ready_count++;
    nxt_task[tid] = NONE_MARK;
    if (last < TASKS) begin
      nxt_task[last[ID_W-1:0]] = PTR_W'(tid);
    end else begin
      lvl_head[lvl] = PTR_W'(tid);
      ready_mask[lvl] = 1'b1;
    end
    lvl_tail[lvl] = PTR_W'(tid);
    busy_id[tid] = 1'b1;
  endfunction

  function automatic logic take_highest(output logic [TID_W-1:0] tid);
    int lvl;
    logic [PTR_W-1:0] first;
    logic [PTR_W-1:0] nx;
    tid = '0;
    if (ready_mask == '0) return 1'b0;
    lvl = LEVELS - 1;
    while (!ready_mask[lvl]) lvl--;
    first = lvl_head[lvl];
    if (first >= TASKS) begin
      lvl_head[lvl] = NONE_MARK;
      lvl_tail[lvl] = NONE_MARK;
      ready_mask[lvl] = 1'b0;
      return 1'b0;
    end
    nx = nxt_task[first[ID_W-1:0]];
    if (nx > TASKS) nx = NONE_MARK;
    if (ready_count != '0) ready_count--;
    lvl_head[lvl] = nx;
    if (nx == NONE_MARK) begin
      lvl_tail[lvl] = NONE_MARK;
      ready_mask[lvl] = 1'b0;
    end
    tid = first[ID_W-1:0];
    busy_id[tid] = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [TID_W-1:0] tid,
                              input logic [PRIO_W-1:0] prio);
    sched_result_t res;
    logic [TID_W-1:0] got;
    logic ok;
    while (idle_enable && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    task_id <= tid;
    task_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res.chosen_valid = 1'b0;
    res.chosen_task = '0;
    res.empty_error = 1'b0;
    if (req == REQ_ADD || req == REQ_YIELD) begin
      queue_task(tid, (prio >= LEVELS) ? LEVELS - 1 : int'(prio));
    end
    if (req == REQ_POP || req == REQ_YIELD) begin
      ok = take_highest(got);
      res.chosen_valid = ok;
      res.chosen_task = ok ? got : '0;
      res.empty_error = !ok;
    end
    res.queued_count = ready_count;
    pending_results.push_back(res);
    @(negedge clk);
  endtask

  task automatic test_empty_scheduler();
    send_request(REQ_POP, 6'd63, 4'd15);
    send_request(REQ_UNUSED, 6'd0, 4'd0);
  endtask

  task automatic test_priority_order();
    send_request(REQ_ADD, 6'd0, 4'd0);
    send_request(REQ_ADD, 6'd63, 4'd15);
    send_request(REQ_ADD, 6'd42, 4'd15);
    send_request(REQ_ADD, 6'd21, 4'd7);
    send_request(REQ_ADD, 6'd33, 4'd7);
    send_request(REQ_POP, 6'd0, 4'd0);
    send_request(REQ_YIELD, 6'd5, 4'd15);
    send_request(REQ_UNUSED, 6'd63, 4'd15);
    send_request(REQ_POP, 6'd0, 4'd0);
    send_request(REQ_POP, 6'd0, 4'd0);
    send_request(REQ_POP, 6'd0, 4'd0);
    send_request(REQ_POP, 6'd0, 4'd0);
    send_request(REQ_POP, 6'd0, 4'd0);
  endtask

  // Queuing a task that is already the tail of its level links it to itself.
  task automatic test_requeue_loop();
    send_request(REQ_ADD, 6'd9, 4'd15);
    send_request(REQ_ADD, 6'd9, 4'd15);
    send_request(REQ_POP, 6'd0, 4'd0);
    send_request(REQ_POP, 6'd0, 4'd0);
    send_request(REQ_POP, 6'd0, 4'd0);
    send_request(REQ_ADD, 6'd17, 4'd15);
    send_request(REQ_POP, 6'd0, 4'd0);
    send_request(REQ_POP, 6'd0, 4'd0);
    send_request(REQ_POP, 6'd0, 4'd0);
  endtask

  task automatic test_random_traffic();
    int n;
    int k;
    int dice;
    int start;
    int add_pct;
    logic found;
    logic [TID_W-1:0] free_tid;
    logic [TID_W-1:0] any_tid;
    logic [PRIO_W-1:0] prio;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_enable = !(n >= 150 && n < 300);
      add_pct = ((n / 100) % 2 == 0) ? 50 : 25;
      any_tid = TID_W'($urandom_range(TASKS - 1));
      prio = $urandom_range(1) ? PRIO_W'($urandom_range(15))
                               : PRIO_W'(15 - 5 * $urandom_range(3));
      start = $urandom_range(TASKS - 1);
      found = 1'b0;
      free_tid = any_tid;
      for (k = 0; k < TASKS; k++) begin
        if (!found && !busy_id[(start + k) % TASKS]) begin
          free_tid = TID_W'((start + k) % TASKS);
          found = 1'b1;
        end
      end
      dice = $urandom_range(99);
      if (dice < 3) begin
        send_request(REQ_UNUSED, any_tid, prio);
      end else if (dice < 6) begin
        send_request(REQ_ADD, any_tid, prio);
      end else begin
        dice = $urandom_range(99);
        if (!found) begin
          send_request(REQ_POP, any_tid, prio);
        end else if (dice < add_pct) begin
          send_request(REQ_ADD, free_tid, prio);
        end else if (dice < 80) begin
          send_request(REQ_POP, any_tid, prio);
        end else begin
          send_request(REQ_YIELD, free_tid, prio);
        end
      end
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_output_backpressure();
    int n;
    hold_left = 80;
    for (n = 0; n < 12; n++) begin
      send_request((n % 3 == 2) ? REQ_POP : REQ_ADD, TID_W'($urandom_range(TASKS - 1)),
                   PRIO_W'($urandom_range(15)));
    end
  endtask

  task automatic test_count_saturation();
    int n;
    for (n = 0; n < 130; n++) begin
      send_request(REQ_ADD, TID_W'(n % TASKS), 4'd3);
    end
    for (n = 0; n < 20; n++) begin
      send_request(REQ_POP, 6'd0, 4'd0);
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_enable && ($urandom_range(99) < 9);
      end
    end
  end

  always @(posedge clk) begin : check_results
    sched_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error("result transaction with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("chosen_valid", 8'(chosen_valid), 8'(want.chosen_valid));
        check_field("chosen_task", 8'(chosen_task), 8'(want.chosen_task));
        check_field("empty_error", 8'(empty_error), 8'(want.empty_error));
        check_field("queued_count", 8'(queued_count), 8'(want.queued_count));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_ADD;
    task_id = '0;
    task_priority = '0;
    for (i = 0; i < TASKS; i++) nxt_task[i] = '0;
    for (i = 0; i < LEVELS; i++) begin
      lvl_head[i] = NONE_MARK;
      lvl_tail[i] = NONE_MARK;
    end
    ready_mask = '0;
    ready_count = '0;
    busy_id = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_empty_scheduler();
    test_priority_order();
    test_requeue_loop();
    test_random_traffic();
    test_output_backpressure();
    test_count_saturation();
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
